### design/pngunf_pkg.sv
// ----------------------------------------------------------------------------
// pngunf_pkg
// Shared types, constants and predictor functions for the PNG unfilter block.
// ----------------------------------------------------------------------------
package pngunf_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int BPP           = 3;
  localparam int CFG_W         = 13;

  // Filter types as written in the row header byte.
  localparam logic [7:0] FTYPE_NONE  = 8'd0;
  localparam logic [7:0] FTYPE_SUB   = 8'd1;
  localparam logic [7:0] FTYPE_UP    = 8'd2;
  localparam logic [7:0] FTYPE_AVG   = 8'd3;
  localparam logic [7:0] FTYPE_PAETH = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH
  } filt_t;

  // One accepted byte as it moves from the row tracker to the reconstruction stage.
  typedef struct packed {
    logic [7:0] data;
    logic       marker;     // filter-type byte, gives no result
    filt_t      filt;
    logic       have_prev;
    logic       last;
  } unf_item_t;

  // Unknown filter types behave as None.
  function automatic filt_t filt_decode(input logic [7:0] code);
    filt_t f;
    unique case (code)
      FTYPE_NONE:  f = FILT_NONE;
      FTYPE_SUB:   f = FILT_SUB;
      FTYPE_UP:    f = FILT_UP;
      FTYPE_AVG:   f = FILT_AVG;
      FTYPE_PAETH: f = FILT_PAETH;
      default:     f = FILT_NONE;
    endcase
    return f;
  endfunction

  function automatic logic [8:0] absdiff9(input logic [8:0] x, input logic [8:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  // a = left, b = up, c = upper left
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [8:0] pa;
    logic [8:0] pb;
    logic [8:0] pc;
    logic [7:0] res;
    pa = absdiff9({1'b0, b}, {1'b0, c});
    pb = absdiff9({1'b0, a}, {1'b0, c});
    pc = absdiff9({1'b0, a} + {1'b0, b}, {c, 1'b0});
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

### design/pngunf_ram.sv
// ----------------------------------------------------------------------------
// pngunf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read word while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/pngunf_front.sv
// ----------------------------------------------------------------------------
// pngunf_front
// Row tracker: width register, column position, filter type, line-buffer read.
// ----------------------------------------------------------------------------
module pngunf_front #(
  parameter int MAX_WIDTH = pngunf_pkg::MAX_WIDTH_DEF,
  localparam int DEPTH = MAX_WIDTH * pngunf_pkg::BPP,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [pngunf_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  input  logic [7:0]                    in_data,
  input  logic                          in_frame_start,
  input  logic                          down_ready,
  output logic                          in_ready,
  output logic                          item_valid,
  output pngunf_pkg::unf_item_t         item,
  output logic [AW-1:0]                 item_idx,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_raddr
);
  import pngunf_pkg::*;

  localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

  logic [CFG_W-1:0] image_width;
  logic [CW-1:0]    column_pos;
  logic [CW-1:0]    column_pos_next;
  logic             have_prev_row;
  logic             have_prev_row_next;
  filt_t            row_filter;

  logic [WW-1:0]    w_ext;
  logic [WW-1:0]    w_clamp;
  logic [CW-1:0]    nbytes;
  logic [CW-1:0]    col_eff;
  logic [CW-1:0]    col_m1;
  logic             hp_eff;
  logic             marker;
  logic             last;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      image_width <= cfg_wr_data;
    end
  end

  // Zero width acts as one pixel, width above the buffer as the buffer size.
  always_comb begin
    w_ext = WW'(image_width);
    if (w_ext == '0) begin
      w_clamp = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    nbytes = CW'(CW'(w_clamp) * CW'(BPP));
  end

  assign in_ready = down_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_eff = in_frame_start ? '0 : column_pos;
    hp_eff  = in_frame_start ? 1'b0 : have_prev_row;
    marker  = (col_eff == '0);
    col_m1  = col_eff - CW'(1);
    last    = !marker && (col_eff >= nbytes);

    if (marker) begin
      column_pos_next    = CW'(1);
      have_prev_row_next = hp_eff;
    end else if (last) begin
      column_pos_next    = '0;
      have_prev_row_next = 1'b1;
    end else begin
      column_pos_next    = col_eff + CW'(1);
      have_prev_row_next = hp_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos    <= '0;
      have_prev_row <= 1'b0;
      row_filter    <= FILT_NONE;
    end else if (accept) begin
      column_pos    <= column_pos_next;
      have_prev_row <= have_prev_row_next;
      if (marker) begin
        row_filter <= filt_decode(in_data);
      end
    end
  end

  assign item_valid     = accept;
  assign item.data      = in_data;
  assign item.marker    = marker;
  assign item.filt      = row_filter;
  assign item.have_prev = hp_eff;
  assign item.last      = last;
  assign item_idx       = col_m1[AW-1:0];

  assign ram_re    = accept && !marker;
  assign ram_raddr = col_m1[AW-1:0];

endmodule

### design/pngunf_recon.sv
// ----------------------------------------------------------------------------
// pngunf_recon
// Reconstruction stage: predictors, pixel history, line-buffer write, output.
// ----------------------------------------------------------------------------
module pngunf_recon #(
  parameter int MAX_WIDTH = pngunf_pkg::MAX_WIDTH_DEF,
  localparam int DEPTH = MAX_WIDTH * pngunf_pkg::BPP,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  pngunf_pkg::unf_item_t in_item,
  input  logic [AW-1:0]         in_idx,
  output logic                  in_ready,
  input  logic [7:0]            ram_rdata,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [7:0]            ram_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_data,
  output logic                  out_last
);
  import pngunf_pkg::*;

  logic          s1_valid;
  unf_item_t     s1;
  logic [AW-1:0] s1_idx;
  logic          s1_adv;

  logic [7:0]    left_hist   [BPP];
  logic [7:0]    upleft_hist [BPP];

  logic [7:0]    left;
  logic [7:0]    up;
  logic [7:0]    upleft;
  logic [7:0]    pred;
  logic [7:0]    recon;
  logic [8:0]    avg_sum;

  // A filter-type byte never needs output space.
  assign s1_adv   = s1_valid && (s1.marker || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1     <= in_item;
      s1_idx <= in_idx;
    end
  end

  always_comb begin
    left    = left_hist[BPP-1];
    upleft  = upleft_hist[BPP-1];
    up      = s1.have_prev ? ram_rdata : 8'd0;
    avg_sum = {1'b0, left} + {1'b0, up};
    unique case (s1.filt)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(left, up, upleft);
      default:    pred = 8'd0;
    endcase
    recon = s1.data + pred;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < BPP; k++) begin
        left_hist[k]   <= 8'd0;
        upleft_hist[k] <= 8'd0;
      end
    end else if (s1_adv) begin
      if (s1.marker) begin
        for (int k = 0; k < BPP; k++) begin
          left_hist[k]   <= 8'd0;
          upleft_hist[k] <= 8'd0;
        end
      end else begin
        left_hist[0]   <= recon;
        upleft_hist[0] <= up;
        for (int k = 1; k < BPP; k++) begin
          left_hist[k]   <= left_hist[k-1];
          upleft_hist[k] <= upleft_hist[k-1];
        end
      end
    end
  end

  assign ram_we    = s1_adv && !s1.marker;
  assign ram_waddr = s1_idx;
  assign ram_wdata = recon;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && !s1.marker) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1.marker) begin
      out_data <= recon;
      out_last <= s1.last;
    end
  end

endmodule

### design/png_scanline_unfilter_rgb8.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_rgb8
// PNG scanline filter removal for 8-bit RGB, one byte per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the filtered byte stream. Each row starts with its filter
//   type byte (None, Sub, Up, Average, Paeth; unknown types pass bytes
//   through), followed by 3*width data bytes. Assert tuser on the first byte
//   of an image; that byte always opens a row, and the first row sees zero
//   for its up neighbors.
//   m_axis returns one reconstructed byte per data byte; tlast marks the last
//   byte of each row. Filter type bytes are absorbed and give no result.
//   cfg_wr_en/cfg_wr_data set the image width in pixels; write only while the
//   stream is idle. Width zero acts as one pixel, widths above MAX_WIDTH
//   as MAX_WIDTH.
// Timing:
//   One byte per clock sustained while m_axis_tready stays high. An accepted
//   request loads the input register at the edge that also reads its up byte
//   from the line buffer; the predictor add then fills the output register
//   once the output is free.
// Reset:
//   Clears row position, filter type, history and both pipeline stages. The
//   line buffer is not cleared; its data is used only after a row has been written.
// Stall:
//   When m_axis_tready is low the result holds; one more data byte is taken
//   into the working stage, then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_rgb8 #(
  parameter int MAX_WIDTH = pngunf_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration: image width in pixels
  input  logic                         cfg_wr_en,
  input  logic [pngunf_pkg::CFG_W-1:0] cfg_wr_data,
  // filtered stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tuser,  // [0] frame_start
  // reconstructed stream out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] recon_byte
  output logic                         m_axis_tlast   // row_end
);
  import pngunf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * BPP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          item_valid;
  unf_item_t     item;
  logic [AW-1:0] item_idx;
  logic          recon_ready;

  // line buffer: previous reconstructed row
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  // Track the row position and issue the up-byte read on accept.
  pngunf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (s_axis_tvalid),
    .in_data        (s_axis_tdata),
    .in_frame_start (s_axis_tuser),
    .down_ready     (recon_ready),
    .in_ready       (s_axis_tready),
    .item_valid     (item_valid),
    .item           (item),
    .item_idx       (item_idx),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr)
  );

  pngunf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Apply the predictor, write back the row, hold the result.
  pngunf_recon #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_recon (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_item   (item),
    .in_idx    (item_idx),
    .in_ready  (recon_ready),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

`ifndef SYNTH
  // The row being written back never collides with the up byte being fetched.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("line buffer read and write hit the same entry");

  // Every line-buffer write comes with a result loaded into the output register.
  a_write_gives_result: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> m_axis_tvalid)
    else $error("line buffer written without a result");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result pending after reset");
`endif

endmodule

### test/png_scanline_unfilter_rgb8_test.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_rgb8_test
// Self-checking bench for the PNG RGB8 scanline unfilter block. A scoreboard
// object predicts every reconstructed byte from the accepted filtered stream.
// Stimulus starts with directed rows for every filter type; the width shrinks
// in the middle of one row. A wider image run without idling follows,
// and then random images with random idling on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module png_scanline_unfilter_rgb8_test;
  import pngunf_pkg::*;

  localparam int         STALL_LIMIT   = 2000;  // cycles with no request moved
  localparam int         CHOKE_CYCLES  = 300;   // long output hold-off
  localparam int         SETTLE_CYCLES = 6;     // covers the two-stage pipe
  localparam int         RANDOM_BYTES  = 680;
  localparam int         LINE_BYTES    = MAX_WIDTH_DEF * BPP;
  localparam logic [7:0] FTYPE_UNKNOWN = 8'hFF; // no such filter, passes through

  // One expected output request.
  typedef struct packed {
    logic [7:0] recon;
    logic       row_end;
  } recon_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the line buffer, row position and
  // neighbor history, and queues the bytes the block must return.
  // --------------------------------------------------------------------------
  class recon_scoreboard;
    logic [7:0]       line_buf [LINE_BYTES];
    logic [CFG_W-1:0] width_px;
    int               col;        // 0: filter byte next, k: data byte k-1 next
    logic [7:0]       row_ftype;
    bit               have_prev;
    logic [7:0]       left_hist [BPP];
    logic [7:0]       upleft_hist [BPP];
    recon_t           recon_due [$];
    int               fails;

    function new();
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      foreach (left_hist[i]) begin
        left_hist[i]   = 8'h00;
        upleft_hist[i] = 8'h00;
      end
      width_px  = 1;
      col       = 0;
      row_ftype = FTYPE_NONE;
      have_prev = 0;
      fails     = 0;
    endfunction

    function void set_width(logic [CFG_W-1:0] w);
      width_px = w;
    endfunction

    function int pending();
      return recon_due.size();
    endfunction

    function void take_request(logic [7:0] din, logic fstart);
      int         row_len;
      int         idx;
      int         a;
      int         b;
      int         c;
      int         p;
      int         pa;
      int         pb;
      int         pc;
      int         pred;
      logic [7:0] recon;
      recon_t     e;
      if (width_px == 0) begin
        row_len = BPP;
      end else if (int'(width_px) > MAX_WIDTH_DEF) begin
        row_len = LINE_BYTES;
      end else begin
        row_len = int'(width_px) * BPP;
      end
      if (fstart) begin
        col       = 0;
        have_prev = 0;
      end
      if (col == 0) begin
        row_ftype = din;
        foreach (left_hist[i]) begin
          left_hist[i]   = 8'h00;
          upleft_hist[i] = 8'h00;
        end
        col = 1;
        return;
      end
      idx = col - 1;
      a   = left_hist[BPP-1];
      c   = upleft_hist[BPP-1];
      b   = (have_prev && idx < LINE_BYTES) ? int'(line_buf[idx]) : 0;
      case (row_ftype)
        FTYPE_SUB:   pred = a;
        FTYPE_UP:    pred = b;
        FTYPE_AVG:   pred = (a + b) / 2;
        FTYPE_PAETH: begin
          p  = a + b - c;
          pa = (p > a) ? p - a : a - p;
          pb = (p > b) ? p - b : b - p;
          pc = (p > c) ? p - c : c - p;
          if (pa <= pb && pa <= pc) begin
            pred = a;
          end else if (pb <= pc) begin
            pred = b;
          end else begin
            pred = c;
          end
        end
        default:     pred = 0;
      endcase
      recon = 8'(int'(din) + pred);
      for (int k = BPP - 1; k > 0; k--) begin
        left_hist[k]   = left_hist[k-1];
        upleft_hist[k] = upleft_hist[k-1];
      end
      left_hist[0]   = recon;
      upleft_hist[0] = 8'(b);
      if (idx < LINE_BYTES) line_buf[idx] = recon;
      e.recon   = recon;
      e.row_end = (idx + 1 >= row_len);
      if (e.row_end) begin
        col       = 0;
        have_prev = 1;
      end else begin
        col = (col + 1) & 'h3FFF;
      end
      recon_due.insert(recon_due.size(), e);
    endfunction

    function void check_recon(logic [7:0] dout, logic last);
      recon_t e;
      if (recon_due.size() == 0) begin
        $error("unexpected result: recon_byte %02h row_end %0b", dout, last);
        fails++;
        return;
      end
      e = recon_due.pop_front();
      if (dout !== e.recon) begin
        $error("recon_byte: expected %02h, actual %02h", e.recon, dout);
        fails++;
      end
      if (last !== e.row_end) begin
        $error("row_end: expected %0b, actual %0b", e.row_end, last);
        fails++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // [7:0] data_byte
  logic             s_axis_tuser;   // [0] frame_start
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;   // [7:0] recon_byte
  logic             m_axis_tlast;   // row_end

  recon_scoreboard  sb;
  bit               calm;           // no idling on either side while set
  bit               choke_req;      // ask the sink for one long hold-off
  int               bytes_sent;
  int               quiet_cycles;

  png_scanline_unfilter_rgb8 dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sample both handshakes at the rising edge. Check the output before noting
  // the input so a result can never be matched against a request taken at
  // the same edge. The watchdog counts edges where nothing moves.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_recon(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) sb.take_request(s_axis_tdata, s_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result sink: draw a hold-off per result, drop tready for that many
  // cycles, then raise it and wait for the handshake. A pending choke request
  // replaces the draw with one long hold-off so the block backs up.
  initial begin : result_sink
    int hold;
    m_axis_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 13);
      if (choke_req) begin
        hold      = CHOKE_CYCLES;
        choke_req = 0;
      end
      if (hold > 0) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Offer one filtered byte after a random gap; return once it is accepted.
  // tvalid stays high so a zero gap gives back-to-back requests.
  task automatic send_byte(input logic [7:0] d, input logic fstart);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= fstart;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Stop offering, wait for every expected byte, then let the pipe settle.
  task automatic drain(input int settle);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Width writes only happen with the block idle.
  task automatic write_width(input logic [CFG_W-1:0] w);
    drain(SETTLE_CYCLES);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    sb.set_width(w);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One image of random rows. The first byte opens a new frame, so the line
  // buffer is never read beyond what the new width has written. Rare
  // frame_start flags on data bytes break rows off in the middle.
  task automatic run_image(input logic [CFG_W-1:0] w, input int rows, input bit pause_mid);
    int         row_bytes;
    logic [7:0] ftype;
    if (w == 0) begin
      row_bytes = BPP;
    end else if (int'(w) > MAX_WIDTH_DEF) begin
      row_bytes = LINE_BYTES;
    end else begin
      row_bytes = int'(w) * BPP;
    end
    write_width(w);
    for (int r = 0; r < rows; r++) begin
      // hold the sender until every result so far has drained
      if (pause_mid && r == rows / 2) drain(0);
      if ($urandom_range(0, 9) == 0) begin
        ftype = 8'($urandom);
      end else begin
        ftype = 8'($urandom_range(FTYPE_NONE, FTYPE_PAETH));
      end
      send_byte(ftype, r == 0);
      for (int i = 0; i < row_bytes; i++) begin
        send_byte(8'($urandom), $urandom_range(0, 299) == 0);
      end
    end
  endtask

  initial begin : stimulus
    int start_count;
    int phase;
    int w;
    sb            = new();
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    calm          = 0;
    choke_req     = 0;
    bytes_sent    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows at two pixels, then one: every filter type, byte extremes,
    // an unknown type passing bytes through.
    write_width(2);
    send_byte(FTYPE_NONE, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(FTYPE_SUB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    // Up row cut short: shrink the width mid-row (zero acts as one pixel),
    // so the next data byte is past the new row length and ends the row.
    send_byte(FTYPE_UP, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    write_width(0);
    send_byte(8'h80, 1'b0);
    send_byte(FTYPE_PAETH, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(FTYPE_AVG, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(FTYPE_UNKNOWN, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);

    // Wider image, two rows so every column is read back. Run it without
    // idling.
    calm = 1;
    run_image(CFG_W'(64), 2, 1'b0);
    calm = 0;

    // Random images, mostly narrow. The first one chokes the output for a
    // long stretch, the second pauses the sender halfway.
    start_count = bytes_sent;
    phase       = 0;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(9, 48);
      end else begin
        w = $urandom_range(0, 8);
      end
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 0) choke_req = 1;
      run_image(CFG_W'(w), $urandom_range(2, 5), phase == 1);
      phase++;
    end
    calm = 0;

    drain(12);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
